/* rtl/core/lpgl_pkg.sv */
package lpgl_pkg;

    localparam int GAIN_SLOTS_DEF   = 10;
    localparam int MAX_CHANNELS_DEF = 8;

    localparam logic [30:0] FULL_SCALE = 31'h7fffffff;

    // configuration register indexes
    localparam logic [1:0] CFG_ATTENUATION  = 2'd0;
    localparam logic [1:0] CFG_CHANNELS     = 2'd1;
    localparam logic [1:0] CFG_BLOCK_FRAMES = 2'd2;

    localparam logic [3:0]  CHANNELS_RST = 4'd2;
    localparam logic [12:0] FRAMES_RST   = 13'd48;

    // one queued item, with its magnitude computed by the front end
    typedef struct packed {
        logic        kind;
        logic [31:0] sample;
        logic [3:0]  gain_slot;
        logic        block_end;
        logic [30:0] mag;
    } item_t;

endpackage

/* rtl/core/lookahead_peak_gain_limiter_unit.sv */
// Look-ahead peak gain limiter. Analysis items (kind 0) feed a block peak
// detector and, on block_end, store a limiting gain into a ring of GAIN_SLOTS
// slots; delayed items (kind 1) come back scaled by a gain that ramps once per
// frame between window minima of the ring, rounded and saturated. A two-entry
// item queue sits between the input front end and the execution engine, and
// the result sits in an output register, so the input keeps flowing while a
// result waits. Items are executed one at a time: an analysis item whose
// block ends with a peak above the headroom threshold also runs the
// one-bit-per-cycle divider. A delayed item is multiplied, rounded and
// delivered; the first one of a block is preceded by the ring scan and the
// ramp-step divide, which shares the same divider. Configuration is taken
// at any time on the cfg port (always ready) but must only change while
// the block is idle.
module lookahead_peak_gain_limiter_unit #(
    parameter int GAIN_SLOTS   = lpgl_pkg::GAIN_SLOTS_DEF,
    parameter int MAX_CHANNELS = lpgl_pkg::MAX_CHANNELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [31:0] sample,
    input  logic [3:0]  gain_slot,
    input  logic        block_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] scaled_sample,
    output logic        last_of_block,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);
    import lpgl_pkg::*;

    logic [1:0]  att_reg;
    logic [3:0]  channels_reg;
    logic [12:0] frames_reg;
    logic        q_valid;
    logic        q_pop;
    item_t       q_item;

    // register writes are always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            att_reg      <= 2'd0;
            channels_reg <= CHANNELS_RST;
            frames_reg   <= FRAMES_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ATTENUATION:  att_reg      <= cfg_data[1:0];
                CFG_CHANNELS:     channels_reg <= cfg_data[3:0];
                CFG_BLOCK_FRAMES: frames_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // compute magnitudes and queue incoming items
    lpgl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .sample    (sample),
        .gain_slot (gain_slot),
        .block_end (block_end),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    // execute: peak, divide, ring scan, ramp, multiply, round
    lpgl_back #(
        .GAIN_SLOTS   (GAIN_SLOTS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .att           (att_reg),
        .channels      (channels_reg),
        .frames        (frames_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .scaled_sample (scaled_sample),
        .last_of_block (last_of_block)
    );

endmodule

/* rtl/core/lpgl_front.sv */
module lpgl_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic           kind,
    input  logic [31:0]    sample,
    input  logic [3:0]     gain_slot,
    input  logic           block_end,
    output logic           q_valid,
    output lpgl_pkg::item_t q_item,
    input  logic           q_pop
);
    import lpgl_pkg::*;

    item_t       fifo_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    logic        pop;
    item_t       item_new;

    // magnitude for the peak detector; the most negative value saturates
    always_comb
    begin
        item_new.kind      = kind;
        item_new.sample    = sample;
        item_new.gain_slot = gain_slot;
        item_new.block_end = block_end;
        if (sample[31])
        begin
            if (sample == 32'h80000000)
                item_new.mag = FULL_SCALE;
            else
                item_new.mag = 31'(-sample);
        end
        else
        begin
            item_new.mag = sample[30:0];
        end
    end

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= item_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

/* rtl/core/lpgl_back.sv */
module lpgl_back #(
    parameter int GAIN_SLOTS   = lpgl_pkg::GAIN_SLOTS_DEF,
    parameter int MAX_CHANNELS = lpgl_pkg::MAX_CHANNELS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [1:0]      att,
    input  logic [3:0]      channels,
    input  logic [12:0]     frames,
    input  logic            q_valid,
    input  lpgl_pkg::item_t q_item,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [31:0]     scaled_sample,
    output logic            last_of_block
);
    import lpgl_pkg::*;

    localparam int IW   = (GAIN_SLOTS > 1) ? $clog2(GAIN_SLOTS) : 1;
    localparam int CW   = $clog2(MAX_CHANNELS + 1);
    localparam int CMPW = 6;
    localparam logic [IW:0] SLOTS = (IW + 1)'(GAIN_SLOTS);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MIN  = 7'b0000010,
        S_STEP = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_FIN  = 7'b0010000,
        S_MUL  = 7'b0100000,
        S_RND  = 7'b1000000
    } state_t;

    state_t       state_reg;
    logic [31:0]  ring_reg [GAIN_SLOTS];
    logic [IW-1:0] ptr_reg;
    logic [30:0]  peak_reg;
    logic [31:0]  gain_reg;
    logic [31:0]  step_reg;
    logic [12:0]  scnt_reg;
    logic [CW-1:0] ccnt_reg;
    logic [31:0]  x_reg;
    logic [3:0]   slot_reg;
    logic [IW-1:0] idx_reg;
    logic [IW:0]  k_reg;
    logic [31:0]  bmin_reg;
    logic [31:0]  emin_reg;
    logic [63:0]  dvd_reg;
    logic [31:0]  rem_reg;
    logic [31:0]  dvs_reg;
    logic [5:0]   dcnt_reg;
    logic         for_step_reg;
    logic         neg_reg;
    logic [63:0]  prod_reg;
    logic         out_valid_reg;
    logic [31:0]  out_data_reg;
    logic         out_last_reg;

    logic [30:0]  peak_new;
    logic [30:0]  thr;
    logic [31:0]  rem_sh;
    logic         ge;
    logic [IW:0]  p2;
    logic [IW-1:0] start_idx;
    logic [IW-1:0] idx_inc;
    logic [32:0]  diff;
    logic [32:0]  adiff;
    logic [63:0]  gshift;
    logic [64:0]  rsum;
    logic [64:0]  rval;
    logic [31:0]  rsat;
    logic [4:0]   sh;
    logic [CMPW-1:0] ch_eff;
    logic [12:0]  fr_eff;
    logic [CMPW-1:0] cc_inc;
    logic [13:0]  sc_inc;
    logic         slot_ok;
    logic         out_free;

    assign thr      = FULL_SCALE >> att;
    assign peak_new = (q_item.mag > peak_reg) ? q_item.mag : peak_reg;
    assign rem_sh   = {rem_reg[30:0], dvd_reg[63]};
    assign ge       = (rem_sh >= dvs_reg);
    assign p2       = {1'b0, ptr_reg} + (IW + 1)'(2);
    assign start_idx = (p2 >= SLOTS) ? IW'(p2 - SLOTS) : p2[IW-1:0];
    assign idx_inc  = ({1'b0, idx_reg} == SLOTS - (IW + 1)'(1)) ? '0 : idx_reg + IW'(1);
    assign diff     = {emin_reg[31], emin_reg} - {bmin_reg[31], bmin_reg};
    assign adiff    = diff[32] ? -diff : diff;
    assign gshift   = dvd_reg >> ({4'd0, att} + 6'd1);
    assign slot_ok  = ({1'b0, slot_reg} < 5'(GAIN_SLOTS));
    assign sh       = 5'd31 - {3'd0, att};
    assign rsum     = {prod_reg[63], prod_reg} + (65'sd1 <<< (sh - 5'd1));
    assign rval     = $signed(rsum) >>> sh;
    assign out_free = !out_valid_reg || !out_stall;
    assign fr_eff   = (frames == 13'd0) ? 13'd1 : frames;
    assign cc_inc   = CMPW'(ccnt_reg) + CMPW'(1);
    assign sc_inc   = {1'b0, scnt_reg} + 14'd1;

    always_comb
    begin
        if (channels == 4'd0)
            ch_eff = CMPW'(1);
        else if (CMPW'(channels) > CMPW'(MAX_CHANNELS))
            ch_eff = CMPW'(MAX_CHANNELS);
        else
            ch_eff = CMPW'(channels);
    end

    // saturate the rounded product to the signed 32-bit range
    always_comb
    begin
        if (!rval[64] && (rval[63:31] != 33'd0))
            rsat = 32'h7fffffff;
        else if (rval[64] && (rval[63:31] != {33{1'b1}}))
            rsat = 32'h80000000;
        else
            rsat = rval[31:0];
    end

    assign q_pop         = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign scaled_sample = out_data_reg;
    assign last_of_block = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL)
            prod_reg <= 64'($signed(x_reg) * $signed(gain_reg));
        if (state_reg == S_RND && out_free)
            out_data_reg <= rsat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            for (int i = 0; i < GAIN_SLOTS; i++)
                ring_reg[i] <= {1'b0, FULL_SCALE};
            ptr_reg       <= '0;
            peak_reg      <= '0;
            gain_reg      <= '0;
            step_reg      <= '0;
            scnt_reg      <= '0;
            ccnt_reg      <= '0;
            x_reg         <= '0;
            slot_reg      <= '0;
            idx_reg       <= '0;
            k_reg         <= '0;
            bmin_reg      <= '0;
            emin_reg      <= '0;
            dvd_reg       <= '0;
            rem_reg       <= '0;
            dvs_reg       <= '0;
            dcnt_reg      <= '0;
            for_step_reg  <= 1'b0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        x_reg    <= q_item.sample;
                        slot_reg <= q_item.gain_slot;
                        if (!q_item.kind)
                        begin
                            if (!q_item.block_end)
                            begin
                                peak_reg <= peak_new;
                            end
                            else if (peak_new > thr)
                            begin
                                peak_reg     <= peak_new;
                                dvd_reg      <= {1'b0, FULL_SCALE, 32'd0};
                                dvs_reg      <= {1'b0, peak_new};
                                rem_reg      <= '0;
                                dcnt_reg     <= '0;
                                for_step_reg <= 1'b0;
                                state_reg    <= S_DIV;
                            end
                            else
                            begin
                                if ({1'b0, q_item.gain_slot} < 5'(GAIN_SLOTS))
                                    ring_reg[q_item.gain_slot[IW-1:0]] <= {1'b0, FULL_SCALE};
                                peak_reg <= '0;
                            end
                        end
                        else if (scnt_reg == 13'd0 && ccnt_reg == '0)
                        begin
                            idx_reg   <= start_idx;
                            k_reg     <= '0;
                            state_reg <= S_MIN;
                        end
                        else
                        begin
                            state_reg <= S_MUL;
                        end
                    end
                end
                // scan the ring once; both windows share all but one slot
                S_MIN:
                begin
                    if (k_reg == '0)
                        bmin_reg <= ring_reg[idx_reg];
                    else if (k_reg <= SLOTS - (IW + 1)'(2)
                             && $signed(ring_reg[idx_reg]) < $signed(bmin_reg))
                        bmin_reg <= ring_reg[idx_reg];
                    if (k_reg == (IW + 1)'(1))
                        emin_reg <= ring_reg[idx_reg];
                    else if (k_reg > (IW + 1)'(1)
                             && $signed(ring_reg[idx_reg]) < $signed(emin_reg))
                        emin_reg <= ring_reg[idx_reg];
                    idx_reg <= idx_inc;
                    k_reg   <= k_reg + (IW + 1)'(1);
                    if (k_reg == SLOTS - (IW + 1)'(1))
                        state_reg <= S_STEP;
                end
                S_STEP:
                begin
                    gain_reg     <= bmin_reg;
                    neg_reg      <= diff[32];
                    dvd_reg      <= {31'd0, adiff};
                    dvs_reg      <= {19'd0, fr_eff};
                    rem_reg      <= '0;
                    dcnt_reg     <= '0;
                    for_step_reg <= 1'b1;
                    state_reg    <= S_DIV;
                end
                // restoring divide, one quotient bit a cycle
                S_DIV:
                begin
                    rem_reg  <= ge ? rem_sh - dvs_reg : rem_sh;
                    dvd_reg  <= {dvd_reg[62:0], ge};
                    dcnt_reg <= dcnt_reg + 6'd1;
                    if (dcnt_reg == 6'd63)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (for_step_reg)
                    begin
                        step_reg  <= neg_reg ? -dvd_reg[31:0] : dvd_reg[31:0];
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        if (slot_ok)
                            ring_reg[slot_reg[IW-1:0]] <= gshift[31:0];
                        peak_reg  <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_RND;
                end
                S_RND:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_last_reg  <= 1'b0;
                        if (cc_inc >= ch_eff)
                        begin
                            ccnt_reg <= '0;
                            gain_reg <= gain_reg + step_reg;
                            if (sc_inc >= {1'b0, fr_eff})
                            begin
                                scnt_reg     <= '0;
                                ptr_reg      <= ({1'b0, ptr_reg} == SLOTS - (IW + 1)'(1))
                                                ? '0 : ptr_reg + IW'(1);
                                out_last_reg <= 1'b1;
                            end
                            else
                            begin
                                scnt_reg <= sc_inc[12:0];
                            end
                        end
                        else
                        begin
                            ccnt_reg <= cc_inc[CW-1:0];
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/core/lpgl_checker.sv */
module lpgl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] scaled_sample,
    input logic        last_of_block
);

    // no result can be presented while reset is applied
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // the queue fills only by taking an item
    a_stall_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid))
        else $error("input stall rose without an item");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(scaled_sample) && $stable(last_of_block))
        else $error("result changed while stalled");

endmodule

bind lookahead_peak_gain_limiter_unit lpgl_checker u_lpgl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .scaled_sample (scaled_sample),
    .last_of_block (last_of_block)
);
